[hdl/qmn_pkg.sv]
// ----------------------------------------------------------------------------
// Quaternion multiply and normalize: shared definitions
// Widths, codes, pipeline depths and sideband types used by every module.
// ----------------------------------------------------------------------------
package qmn_pkg;

    localparam int DW     = 16;  // component width, signed
    localparam int FB     = 12;  // fraction bits
    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;

    localparam int PW  = 2 * DW;       // full product width
    localparam int SW  = PW + 2;       // sum of four products
    localparam int QW  = PW + 1;       // sum of four squares
    localparam int SQ_IT  = QW / 2 + 1; // square root iterations
    localparam int RW     = SQ_IT;      // root and divisor magnitude width
    localparam int SQ_LAT = SQ_IT + 1;  // iterations plus rounding stage
    localparam int NW  = DW + FB + 1;  // dividend width
    localparam int DVW = RW + 1;       // doubled divisor width
    localparam int DIV_LAT = NW;       // one quotient bit per stage

    localparam int IN_W      = ACT_W + 9 * DW;
    localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W     = 4 * DW + STAT_W;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [ACT_W-1:0] ACT_MUL  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DIV  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_NORM = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SAT  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO = 2'd2;

    localparam logic signed [SW-1:0] SMAX     = SW'((64'sd1 <<< (DW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SMIN     = -SMAX - SW'(1);
    localparam logic signed [SW-1:0] RND_HALF = SW'(64'sd1 <<< (FB - 1));
    localparam logic [NW-1:0] QPOS_MAX = NW'((64'd1 << (DW - 1)) - 64'd1);
    localparam logic [NW-1:0] QNEG_MAX = NW'(64'd1 << (DW - 1));

    typedef struct packed {
        logic                     valid;
        logic [ACT_W-1:0]         act;
        logic [3:0][DW-1:0]       a;
        logic [DW-1:0]            scal;
        logic [3:0][DW-1:0]       mres;
        logic                     msat;
    } side_t;

    typedef struct packed {
        logic                     valid;
        logic [ACT_W-1:0]         act;
        logic [3:0]               neg;
        logic                     zero;
        logic [3:0][DW-1:0]       mres;
        logic                     msat;
    } div_side_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [3:0][DW-1:0]       comp;
    } result_t;

endpackage

[hdl/qmn_isqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, then a stage that rounds to nearest.
// ----------------------------------------------------------------------------
module qmn_isqrt
    import qmn_pkg::*;
(
    input  logic          aclk,
    input  logic          en,
    input  logic [QW-1:0] rad,
    output logic [RW-1:0] root
);

    logic [QW-1:0] rem_reg  [SQ_IT];
    logic [QW-1:0] root_reg [SQ_IT];
    logic [QW-1:0] rnd_reg;
    logic [QW-1:0] rnd_next;

    for (genvar k = 0; k < SQ_IT; k++) begin : g_it
        localparam logic [QW:0] BITV = (QW + 1)'(1) << (2 * (SQ_IT - 1 - k));
        logic [QW-1:0] rem_p;
        logic [QW-1:0] root_p;
        logic [QW-1:0] rem_next;
        logic [QW-1:0] root_next;
        logic [QW:0]   trial;

        if (k == 0) begin : g_first
            assign rem_p  = rad;
            assign root_p = '0;
        end else begin : g_rest
            assign rem_p  = rem_reg[k-1];
            assign root_p = root_reg[k-1];
        end

        always_comb begin
            trial = {1'b0, root_p} + BITV;
            if ({1'b0, rem_p} >= trial) begin
                rem_next  = rem_p - trial[QW-1:0];
                root_next = (root_p >> 1) + BITV[QW-1:0];
            end else begin
                rem_next  = rem_p;
                root_next = root_p >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    always_comb begin
        rnd_next = root_reg[SQ_IT-1];
        if (rem_reg[SQ_IT-1] > root_reg[SQ_IT-1]) begin
            rnd_next = root_reg[SQ_IT-1] + QW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rnd_reg <= rnd_next;
        end
    end

    assign root = rnd_reg[RW-1:0];

endmodule

[hdl/qmn_div.sv]
// ----------------------------------------------------------------------------
// Pipelined four-lane restoring divider
// All lanes share one divisor; each stage resolves one quotient bit.
// ----------------------------------------------------------------------------
module qmn_div
    import qmn_pkg::*;
(
    input  logic           aclk,
    input  logic           en,
    input  logic [NW-1:0]  num [4],
    input  logic [DVW-1:0] den,
    output logic [NW-1:0]  quo [4]
);

    logic [DVW-1:0] rem_reg [NW][4];
    logic [NW-1:0]  num_reg [NW][4];
    logic [NW-1:0]  quo_reg [NW][4];
    logic [DVW-1:0] den_reg [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DVW-1:0] den_p;
        logic [DVW-1:0] rem_p  [4];
        logic [NW-1:0]  num_p  [4];
        logic [NW-1:0]  quo_p  [4];
        logic [DVW-1:0] rem_next [4];
        logic [NW-1:0]  quo_next [4];
        logic [DVW:0]   trial  [4];

        if (k == 0) begin : g_first
            assign den_p = den;
            for (genvar l = 0; l < 4; l++) begin : g_lane
                assign rem_p[l] = '0;
                assign num_p[l] = num[l];
                assign quo_p[l] = '0;
            end
        end else begin : g_rest
            assign den_p = den_reg[k-1];
            for (genvar l = 0; l < 4; l++) begin : g_lane
                assign rem_p[l] = rem_reg[k-1][l];
                assign num_p[l] = num_reg[k-1][l];
                assign quo_p[l] = quo_reg[k-1][l];
            end
        end

        always_comb begin
            for (int l = 0; l < 4; l++) begin
                trial[l] = {rem_p[l], num_p[l][NW-1]};
                if (trial[l] >= {1'b0, den_p}) begin
                    rem_next[l] = DVW'(trial[l] - {1'b0, den_p});
                    quo_next[l] = {quo_p[l][NW-2:0], 1'b1};
                end else begin
                    rem_next[l] = trial[l][DVW-1:0];
                    quo_next[l] = {quo_p[l][NW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[k] <= den_p;
                for (int l = 0; l < 4; l++) begin
                    rem_reg[k][l] <= rem_next[l];
                    num_reg[k][l] <= num_p[l] << 1;
                    quo_reg[k][l] <= quo_next[l];
                end
            end
        end
    end

    assign quo = quo_reg[NW-1];

endmodule

[hdl/quaternion_multiply_normalize_unit.sv]
// ----------------------------------------------------------------------------
// Quaternion multiply, divide-by-scalar and normalize unit
// Signed fixed-point Hamilton product, scalar division and normalization.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on the s_ channel carries an action and the operands; each
// produces exactly one transaction on the m_ channel, in order.
// s_tdata: action, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scalar (low first).
// m_tdata: out_w, out_x, out_y, out_z, status (low first).
// The datapath is a 50-stage pipeline: products, sums, a 17-step square root
// with a rounding stage, operand setup and a 29-step restoring divider.
// Throughput is one transaction per cycle for every action while the output
// is not stalled. A two-entry output buffer sits after the pipeline. When the
// receiver stalls, the pipeline keeps moving until both entries are full and
// a valid result waits at its end; then the whole pipeline holds and s_tready
// drops; nothing is dropped or repeated. Reset clears all valid bits and
// empties the output buffer; the data registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_multiply_normalize_unit
    import qmn_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // action, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scalar, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_w, out_x, out_y, out_z, status, zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic                   en;
    logic                   accept;
    logic [ACT_W-1:0]       in_action;
    logic signed [DW-1:0]   in_a [4];
    logic signed [DW-1:0]   in_b [4];
    logic signed [DW-1:0]   in_scalar;

    assign in_action = s_tdata[ACT_W-1:0];
    assign in_scalar = s_tdata[ACT_W+8*DW +: DW];
    for (genvar i = 0; i < 4; i++) begin : g_unpack
        assign in_a[i] = s_tdata[ACT_W+i*DW +: DW];
        assign in_b[i] = s_tdata[ACT_W+(4+i)*DW +: DW];
    end

    // Stage 1: all products.
    logic                 v1_reg;
    logic [ACT_W-1:0]     act1_reg;
    logic signed [DW-1:0] a1_reg [4];
    logic [DW-1:0]        scal1_reg;
    logic signed [PW-1:0] prod1_reg [4][4];
    logic [PW-1:0]        sq1_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act1_reg  <= in_action;
            scal1_reg <= in_scalar;
            for (int i = 0; i < 4; i++) begin
                a1_reg[i]  <= in_a[i];
                sq1_reg[i] <= in_a[i] * in_a[i];
                for (int j = 0; j < 4; j++) begin
                    prod1_reg[i][j] <= in_a[i] * in_b[j];
                end
            end
        end
    end

    // Stage 2: Hamilton sums with rounding and clamping, sum of squares.
    function automatic logic signed [SW-1:0] sx(input logic signed [PW-1:0] p);
        return {{(SW-PW){p[PW-1]}}, p};
    endfunction

    logic signed [SW-1:0] msum  [4];
    logic signed [SW-1:0] mbias [4];
    logic signed [SW-1:0] mshift[4];
    logic [3:0][DW-1:0]   mres_next;
    logic                 msat_next;
    logic [QW-1:0]        ssq_next;
    side_t                side2_reg;
    side_t                side2_next;
    logic [QW-1:0]        ssq2_reg;

    always_comb begin
        msum[0] = sx(prod1_reg[0][0]) - sx(prod1_reg[1][1])
                - sx(prod1_reg[2][2]) - sx(prod1_reg[3][3]);
        msum[1] = sx(prod1_reg[0][1]) + sx(prod1_reg[1][0])
                + sx(prod1_reg[2][3]) - sx(prod1_reg[3][2]);
        msum[2] = sx(prod1_reg[0][2]) + sx(prod1_reg[2][0])
                + sx(prod1_reg[3][1]) - sx(prod1_reg[1][3]);
        msum[3] = sx(prod1_reg[0][3]) + sx(prod1_reg[3][0])
                + sx(prod1_reg[1][2]) - sx(prod1_reg[2][1]);
        msat_next = 1'b0;
        for (int c = 0; c < 4; c++) begin
            mbias[c]  = msum[c] + RND_HALF;
            mshift[c] = mbias[c] >>> FB;
            if (mshift[c] > SMAX) begin
                mres_next[c] = SMAX[DW-1:0];
                msat_next    = 1'b1;
            end else if (mshift[c] < SMIN) begin
                mres_next[c] = SMIN[DW-1:0];
                msat_next    = 1'b1;
            end else begin
                mres_next[c] = mshift[c][DW-1:0];
            end
        end
        ssq_next = QW'(sq1_reg[0]) + QW'(sq1_reg[1]) + QW'(sq1_reg[2]) + QW'(sq1_reg[3]);

        side2_next.valid = v1_reg;
        side2_next.act   = act1_reg;
        side2_next.scal  = scal1_reg;
        for (int i = 0; i < 4; i++) begin
            side2_next.a[i] = a1_reg[i];
        end
        side2_next.mres = mres_next;
        side2_next.msat = msat_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side2_reg.valid <= 1'b0;
        end else if (en) begin
            side2_reg <= side2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ssq2_reg <= ssq_next;
        end
    end

    // Square root, with the sideband delayed alongside it.
    logic [RW-1:0] root;
    side_t         sq_side_reg [SQ_LAT];

    qmn_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (ssq2_reg),
        .root (root)
    );

    for (genvar k = 0; k < SQ_LAT; k++) begin : g_sq_side
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_side_reg[k].valid <= 1'b0;
            end else if (en) begin
                sq_side_reg[k] <= (k == 0) ? side2_reg : sq_side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // Operand setup for the divider.
    side_t                sq_out;
    logic [RW-1:0]        dmag;
    logic signed [RW-1:0] scal_ext;
    logic                 dneg;
    logic signed [DW:0]   a_ext [4];
    logic [DW:0]          a_abs [4];
    logic [NW-1:0]        num_next [4];
    div_side_t            dside_next;
    div_side_t            dside4_reg;
    logic [NW-1:0]        num4_reg [4];
    logic [DVW-1:0]       den4_reg;

    assign sq_out = sq_side_reg[SQ_LAT-1];

    always_comb begin
        scal_ext = {{(RW-DW){sq_out.scal[DW-1]}}, sq_out.scal};
        dneg     = (sq_out.act == ACT_DIV) && sq_out.scal[DW-1];
        if (sq_out.act == ACT_DIV) begin
            dmag = scal_ext[RW-1] ? RW'(-scal_ext) : RW'(scal_ext);
        end else begin
            dmag = root;
        end
        for (int i = 0; i < 4; i++) begin
            a_ext[i]          = {sq_out.a[i][DW-1], sq_out.a[i]};
            a_abs[i]          = a_ext[i][DW] ? (DW+1)'(-a_ext[i]) : (DW+1)'(a_ext[i]);
            num_next[i]       = (NW'(a_abs[i]) << (FB + 1)) + NW'(dmag);
            dside_next.neg[i] = sq_out.a[i][DW-1] ^ dneg;
        end
        dside_next.valid = sq_out.valid;
        dside_next.act   = sq_out.act;
        dside_next.zero  = (dmag == '0);
        dside_next.mres  = sq_out.mres;
        dside_next.msat  = sq_out.msat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dside4_reg.valid <= 1'b0;
        end else if (en) begin
            dside4_reg <= dside_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den4_reg <= {dmag, 1'b0};
            for (int i = 0; i < 4; i++) begin
                num4_reg[i] <= num_next[i];
            end
        end
    end

    // Divider, with the sideband delayed alongside it.
    logic [NW-1:0] quo [4];
    div_side_t     dv_side_reg [DIV_LAT];

    qmn_div u_div (
        .aclk (aclk),
        .en   (en),
        .num  (num4_reg),
        .den  (den4_reg),
        .quo  (quo)
    );

    for (genvar k = 0; k < DIV_LAT; k++) begin : g_dv_side
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_side_reg[k].valid <= 1'b0;
            end else if (en) begin
                dv_side_reg[k] <= (k == 0) ? dside4_reg : dv_side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // Final sign, clamp and action select.
    div_side_t dv_out;
    result_t   fin;
    logic      dsat;
    logic [3:0][DW-1:0] dres;

    assign dv_out = dv_side_reg[DIV_LAT-1];

    always_comb begin
        dsat = 1'b0;
        for (int l = 0; l < 4; l++) begin
            if (dv_out.neg[l]) begin
                if (quo[l] > QNEG_MAX) begin
                    dres[l] = SMIN[DW-1:0];
                    dsat    = 1'b1;
                end else begin
                    dres[l] = DW'(-quo[l]);
                end
            end else begin
                if (quo[l] > QPOS_MAX) begin
                    dres[l] = SMAX[DW-1:0];
                    dsat    = 1'b1;
                end else begin
                    dres[l] = quo[l][DW-1:0];
                end
            end
        end
        fin.comp   = '0;
        fin.status = STAT_OK;
        if (dv_out.act == ACT_MUL) begin
            fin.comp   = dv_out.mres;
            fin.status = dv_out.msat ? STAT_SAT : STAT_OK;
        end else if (dv_out.act inside {ACT_DIV, ACT_NORM}) begin
            if (dv_out.zero) begin
                fin.status = STAT_ZERO;
            end else begin
                fin.comp   = dres;
                fin.status = dsat ? STAT_SAT : STAT_OK;
            end
        end
    end

    // Two-entry output buffer.
    logic [1:0] ob_cnt_reg;
    logic [1:0] ob_cnt_next;
    result_t    ob0_reg;
    result_t    ob0_next;
    result_t    ob1_reg;
    result_t    ob1_next;
    logic       push;
    logic       pop;

    assign en       = !dv_out.valid || (ob_cnt_reg != 2'd2) || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;
    assign push     = en && dv_out.valid;
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (ob_cnt_reg != 2'd0);
    assign m_tdata  = M_TDATA_W'(ob0_reg);

    always_comb begin
        ob0_next    = ob0_reg;
        ob1_next    = ob1_reg;
        ob_cnt_next = ob_cnt_reg;
        if (pop && push) begin
            if (ob_cnt_reg == 2'd2) begin
                ob0_next = ob1_reg;
                ob1_next = fin;
            end else begin
                ob0_next = fin;
            end
        end else if (pop) begin
            ob0_next    = ob1_reg;
            ob_cnt_next = ob_cnt_reg - 2'd1;
        end else if (push) begin
            if (ob_cnt_reg == 2'd0) begin
                ob0_next = fin;
            end else begin
                ob1_next = fin;
            end
            ob_cnt_next = ob_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_cnt_reg <= 2'd0;
        end else begin
            ob_cnt_reg <= ob_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ob0_reg <= ob0_next;
        ob1_reg <= ob1_next;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ob_cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (ob_cnt_reg == 2'd2) && dv_out.valid)
        else $error("input stalled while the output buffer had room");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ob0_reg.status != 2'd3)
        else $error("undefined status code");

    a_zero_comps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (ob0_reg.status == STAT_ZERO) |-> (ob0_reg.comp == '0))
        else $error("zero divisor result with nonzero components");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(dv_out.valid) && $stable(ob_cnt_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule
